// ===== rtl/pis_pkg.sv =====
// Shared constants for the permutation inverse shortcut unit.
// Used by the channel interfaces and the top level; no dependencies.
package pis_pkg;
   localparam int DEPTH      = 1024;
   localparam int ADDR_BITS  = 10;
   localparam int VALUE_BITS = 10;
   localparam int CNT_BITS   = 11;
   localparam int CSR_BITS   = 11;
   localparam int IDX_BITS   = 2;
   localparam int FLAG_BITS  = 2;

   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_BUILD   = 2'd1;
   localparam logic [1:0] OP_INVERSE = 2'd2;
   localparam logic [1:0] OP_FORWARD = 2'd3;

   localparam logic [1:0] KIND_BUILD   = 2'd0;
   localparam logic [1:0] KIND_INVERSE = 2'd1;
   localparam logic [1:0] KIND_FORWARD = 2'd2;

   localparam logic [IDX_BITS-1:0] CSR_STRIDE = 2'd0;
   localparam logic [IDX_BITS-1:0] CSR_COUNT  = 2'd1;

   // flag word: visited in bit 0, shortcut mark in bit 1
   localparam int FLAG_VISITED = 0;
   localparam int FLAG_MARK    = 1;
endpackage

// ===== rtl/pis_if.sv =====
// Valid/ready channel interfaces for request, response and CSR writes.
// Depends on pis_pkg for field widths.
interface pis_req_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      opcode;
   logic [pis_pkg::ADDR_BITS-1:0]   position;
   logic [pis_pkg::VALUE_BITS-1:0]  entry_value;
   modport source (output valid, opcode, position, entry_value, input ready);
   modport sink   (input valid, opcode, position, entry_value, output ready);
endinterface

interface pis_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [pis_pkg::VALUE_BITS-1:0]  answer;
   logic [1:0]                      answer_kind;
   modport source (output valid, answer, answer_kind, input ready);
   modport sink   (input valid, answer, answer_kind, output ready);
endinterface

interface pis_csr_if;
   logic                            valid;
   logic                            ready;
   logic [pis_pkg::IDX_BITS-1:0]    index;
   logic [pis_pkg::CSR_BITS-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/permutation_inverse_shortcut_unit.sv =====
// Permutation store with shortcut back pointers; forward and inverse queries.
// Depends on pis_pkg, pis_if and pis_ram.
//
// Holds a permutation of up to 1024 entries in RAM. A load writes its entry from idle and
// gives no response. A forward query reads the entry. An inverse query walks forward from
// the position; at the first element with the shortcut mark it jumps back by that element's
// back pointer and walks forward again to the preimage; each walk is bounded by the entry
// count. A build first sweeps the flag RAM, then walks each unvisited permutation cycle
// from each start index. After reset the flag RAM is swept with no request taken. Walking
// uses one RAM read per step. A result waits in an output register; the next request is
// taken while it waits. Queries are meaningful only after a build.
module permutation_inverse_shortcut_unit (
   input  logic        clock,
   input  logic        reset,
   pis_req_if.sink     req,
   pis_rsp_if.source   rsp,
   pis_csr_if.sink     csr
);
   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_SCAN, ST_SCHK, ST_WRD, ST_WGOTP, ST_WGOTF, ST_WEND,
      ST_QRD, ST_QGOT, ST_QBP, ST_FGOT, ST_OUT
   } state_type;

   localparam int AB = pis_pkg::ADDR_BITS;
   localparam int VB = pis_pkg::VALUE_BITS;
   localparam int CB = pis_pkg::CNT_BITS;
   localparam int FB = pis_pkg::FLAG_BITS;

   state_type         state_ff;
   logic [CB-1:0]     stride_ff, count_ff;
   logic [CB-1:0]     clr_ff, s_ff, cnt_ff, steps_ff;
   logic [AB-1:0]     j_ff, e_ff, bptr_ff, y_ff;
   logic              build_ff, phase_ff;
   logic [VB-1:0]     ans_ff, rsp_ans_ff;
   logic [1:0]        kind_ff, rsp_kind_ff;
   logic              rsp_valid_ff;

   logic [CB-1:0]     n_eff, t_eff, cnt_in;
   logic              req_fire, mark_in;

   logic              perm_we, flag_we, bp_we;
   logic [AB-1:0]     perm_wa, perm_ra, flag_wa, flag_ra, bp_wa;
   logic [VB-1:0]     perm_wd, perm_rd, bp_wd, bp_rd;
   logic [FB-1:0]     flag_wd, flag_rd;

   assign n_eff = (count_ff > CB'(pis_pkg::DEPTH)) ? CB'(pis_pkg::DEPTH) : count_ff;
   assign t_eff = (stride_ff == '0) ? CB'(1) : stride_ff;
   assign cnt_in = cnt_ff + CB'(1);
   assign mark_in = (cnt_in >= t_eff);

   assign req.ready = (state_ff == ST_IDLE);
   assign req_fire = req.valid && req.ready;
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.answer = rsp_ans_ff;
   assign rsp.answer_kind = rsp_kind_ff;

   // RAM port steering
   always_comb begin
      perm_we = req_fire && (req.opcode == pis_pkg::OP_LOAD);
      perm_wa = req.position;
      perm_wd = req.entry_value;
      perm_ra = (state_ff == ST_IDLE) ? req.position : j_ff;

      flag_ra = j_ff;
      if (state_ff == ST_SCAN) begin
         flag_ra = s_ff[AB-1:0];
      end else if (state_ff == ST_WGOTP) begin
         flag_ra = perm_rd;
      end

      flag_we = 1'b0;
      flag_wa = s_ff[AB-1:0];
      flag_wd = '0;
      bp_we = 1'b0;
      bp_wa = s_ff[AB-1:0];
      bp_wd = bptr_ff;
      case (state_ff)
         ST_CLEAR: begin
            flag_we = 1'b1;
            flag_wa = clr_ff[AB-1:0];
         end
         ST_SCHK: begin
            flag_we = !flag_rd[pis_pkg::FLAG_VISITED];
            flag_wd = FB'(1) << pis_pkg::FLAG_VISITED;
         end
         ST_WGOTF: begin
            flag_we = !flag_rd[pis_pkg::FLAG_VISITED];
            flag_wa = e_ff;
            flag_wd = (FB'(1) << pis_pkg::FLAG_VISITED)
                    | (FB'(mark_in) << pis_pkg::FLAG_MARK);
            bp_we = flag_we && mark_in;
            bp_wa = e_ff;
         end
         ST_WEND: begin
            // close a long cycle: mark its start too
            flag_we = (steps_ff >= t_eff);
            flag_wd = (FB'(1) << pis_pkg::FLAG_VISITED) | (FB'(1) << pis_pkg::FLAG_MARK);
            bp_we = flag_we;
         end
         default: begin
         end
      endcase
   end

   pis_ram #(.WIDTH(VB), .DEPTH(pis_pkg::DEPTH)) u_perm (
      .clock(clock), .wr_en(perm_we), .wr_addr(perm_wa), .wr_data(perm_wd),
      .rd_addr(perm_ra), .rd_data(perm_rd)
   );

   pis_ram #(.WIDTH(FB), .DEPTH(pis_pkg::DEPTH)) u_flag (
      .clock(clock), .wr_en(flag_we), .wr_addr(flag_wa), .wr_data(flag_wd),
      .rd_addr(flag_ra), .rd_data(flag_rd)
   );

   pis_ram #(.WIDTH(VB), .DEPTH(pis_pkg::DEPTH)) u_bptr (
      .clock(clock), .wr_en(bp_we), .wr_addr(bp_wa), .wr_data(bp_wd),
      .rd_addr(j_ff), .rd_data(bp_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         build_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         stride_ff <= CB'(1);
         count_ff <= CB'(pis_pkg::DEPTH);
      end else begin
         if (csr.valid && csr.ready) begin
            if (csr.index == pis_pkg::CSR_STRIDE) begin
               stride_ff <= csr.data;
            end else if (csr.index == pis_pkg::CSR_COUNT) begin
               count_ff <= csr.data;
            end
         end
         // the output state reloads the response register itself
         if (rsp_valid_ff && rsp.ready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + CB'(1);
               if (clr_ff == CB'(pis_pkg::DEPTH - 1)) begin
                  s_ff <= '0;
                  state_ff <= build_ff ? ST_SCAN : ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_fire) begin
                  y_ff <= req.position;
                  j_ff <= req.position;
                  steps_ff <= '0;
                  phase_ff <= 1'b0;
                  ans_ff <= '0;
                  case (req.opcode)
                     pis_pkg::OP_BUILD: begin
                        build_ff <= 1'b1;
                        clr_ff <= '0;
                        state_ff <= ST_CLEAR;
                     end
                     pis_pkg::OP_INVERSE: begin
                        kind_ff <= pis_pkg::KIND_INVERSE;
                        state_ff <= ({1'b0, req.position} >= n_eff) ? ST_OUT : ST_QRD;
                     end
                     pis_pkg::OP_FORWARD: begin
                        kind_ff <= pis_pkg::KIND_FORWARD;
                        state_ff <= ({1'b0, req.position} >= n_eff) ? ST_OUT : ST_FGOT;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               if (s_ff >= n_eff) begin
                  ans_ff <= '0;
                  kind_ff <= pis_pkg::KIND_BUILD;
                  build_ff <= 1'b0;
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_SCHK;
               end
            end
            ST_SCHK: begin
               if (flag_rd[pis_pkg::FLAG_VISITED]) begin
                  s_ff <= s_ff + CB'(1);
                  state_ff <= ST_SCAN;
               end else begin
                  j_ff <= s_ff[AB-1:0];
                  bptr_ff <= s_ff[AB-1:0];
                  cnt_ff <= '0;
                  steps_ff <= '0;
                  state_ff <= ST_WRD;
               end
            end
            ST_WRD: begin
               state_ff <= (steps_ff >= n_eff) ? ST_WEND : ST_WGOTP;
            end
            ST_WGOTP: begin
               e_ff <= perm_rd;
               if (({1'b0, perm_rd} == s_ff) || ({1'b0, perm_rd} >= n_eff)) begin
                  state_ff <= ST_WEND;
               end else begin
                  state_ff <= ST_WGOTF;
               end
            end
            ST_WGOTF: begin
               if (flag_rd[pis_pkg::FLAG_VISITED]) begin
                  state_ff <= ST_WEND;
               end else begin
                  j_ff <= e_ff;
                  steps_ff <= steps_ff + CB'(1);
                  if (mark_in) begin
                     cnt_ff <= '0;
                     bptr_ff <= e_ff;
                  end else begin
                     cnt_ff <= cnt_in;
                  end
                  state_ff <= ST_WRD;
               end
            end
            ST_WEND: begin
               s_ff <= s_ff + CB'(1);
               state_ff <= ST_SCAN;
            end
            ST_QRD: begin
               state_ff <= (steps_ff >= n_eff) ? ST_OUT : ST_QGOT;
            end
            ST_QGOT: begin
               if (perm_rd == y_ff) begin
                  ans_ff <= j_ff;
                  state_ff <= ST_OUT;
               end else if (!phase_ff && flag_rd[pis_pkg::FLAG_MARK]) begin
                  state_ff <= ST_QBP;
               end else if ({1'b0, perm_rd} >= n_eff) begin
                  state_ff <= ST_OUT;
               end else begin
                  j_ff <= perm_rd;
                  steps_ff <= steps_ff + CB'(1);
                  state_ff <= ST_QRD;
               end
            end
            ST_QBP: begin
               // jump back by the shortcut, then walk forward
               if ({1'b0, bp_rd} >= n_eff) begin
                  state_ff <= ST_OUT;
               end else begin
                  j_ff <= bp_rd;
                  steps_ff <= '0;
                  phase_ff <= 1'b1;
                  state_ff <= ST_QRD;
               end
            end
            ST_FGOT: begin
               ans_ff <= perm_rd;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ans_ff <= ans_ff;
                  rsp_kind_ff <= kind_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   a_mark_has_pointer: assert property (@(posedge clock) disable iff (reset)
      (flag_we && flag_wd[pis_pkg::FLAG_MARK]) |-> (bp_we && bp_wa == flag_wa))
      else $error("mark written without its back pointer");

   a_busy_after_item: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req.opcode != pis_pkg::OP_LOAD) |=> !req.ready)
      else $error("request taken while an item is in work");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("response raised outside the output state");
endmodule

// ===== rtl/pis_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pis_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
